FILE: design/cad_pkg.sv
`timescale 1ns / 1ps

package cad_pkg;

  localparam int DEPTH_DEF = 1024;

  // Command codes
  typedef enum logic [3:0] {
    FN_CLEAR     = 4'd0,
    FN_APPEND    = 4'd1,
    FN_PREPEND   = 4'd2,
    FN_PEEK_FRNT = 4'd3,
    FN_PEEK_POS  = 4'd4,
    FN_REWIND    = 4'd5,
    FN_NEXT      = 4'd6,
    FN_SIZE      = 4'd7,
    FN_SELECT    = 4'd8,
    FN_FLIP      = 4'd9,
    FN_SET_END   = 4'd10,
    FN_GET_END   = 4'd11
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Captured command
  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] seg_index;
    logic [63:0]        arc_word;
    logic signed [10:0] position;
    logic [9:0]         window_start;
    logic [10:0]        window_length;
    logic [63:0]        front_data_a;
    logic [63:0]        front_data_b;
    logic [63:0]        back_data_a;
    logic [63:0]        back_data_b;
  } cmd_t;

endpackage

FILE: design/centered_array_deque.sv
`timescale 1ns / 1ps

// Double-ended queue of (segment index, arc word) entries in one entry memory.
//
// Command channel: drive in_* and raise start; the command transfers at the
// rising edge where start is high and busy is low. One result per command
// appears on out_* for exactly one cycle, marked by out_valid; the receiver
// cannot stall, so results never back up.
//
// Timing: a command is captured at its transfer edge, executed in the next
// cycle (one access of the single-port entry memory plus pointer updates),
// and its result is shown in the cycle after that. A new command can transfer
// only once the execute cycle is over, held off by the capture/execute loop
// around the memory port. busy is high during the execute cycle.
//
// Reset (rst_n low, synchronous): pointers go to mid-array (empty queue),
// the reversed flag and both end-data pairs clear, no result is pending.
// The entry memory is not cleared: entries read before they are written are
// undefined. Flip toggles the reversed flag so entries never move.

module centered_array_deque
  import cad_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_seg_index,
  input  logic [63:0]        in_arc_word,
  input  logic signed [10:0] in_position,
  input  logic [9:0]         in_window_start,
  input  logic [10:0]        in_window_length,
  input  logic [63:0]        in_front_data_a,
  input  logic [63:0]        in_front_data_b,
  input  logic [63:0]        in_back_data_a,
  input  logic [63:0]        in_back_data_b,
  // result channel
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_read_index,
  output logic [63:0]        out_read_arc,
  output logic [10:0]        out_entry_count,
  output logic               out_at_extremity,
  output logic [63:0]        out_end_data_a,
  output logic [63:0]        out_end_data_b
);

  localparam int AW = $clog2(DEPTH);
  // pointer width: front 0..DEPTH, back -1..DEPTH-1, signed
  localparam int PW = AW + 2;
  // compute width: covers front + window_start + window_length
  localparam int SW = ((PW > 12) ? PW : 12) + 2;

  localparam logic signed [SW-1:0] D_S      = SW'(DEPTH);
  localparam logic signed [SW-1:0] DM1_S    = SW'(DEPTH - 1);
  localparam logic signed [SW-1:0] HALF_S   = SW'(DEPTH / 2);
  localparam logic signed [SW-1:0] HALFM1_S = SW'(DEPTH / 2 - 1);
  localparam logic signed [SW-1:0] ONE_S    = SW'(1);
  localparam logic signed [SW-1:0] ZERO_S   = SW'(0);

  function automatic logic signed [SW-1:0] sx(input logic [PW-1:0] v);
    return {{(SW-PW){v[PW-1]}}, v};
  endfunction

  // logical slot to physical memory address
  function automatic logic [AW-1:0] phys_addr(input logic signed [SW-1:0] l,
                                              input logic rev);
    logic signed [SW-1:0] m;
    m = rev ? (DM1_S - l) : l;
    return m[AW-1:0];
  endfunction

  // ---------------- control FSM
  state_t state_r, state_nxt;
  logic   accept;
  logic   exec_en;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    exec_en   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        exec_en   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------- command capture
  cmd_t cmd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= '{func:          in_func,
                 seg_index:     in_seg_index,
                 arc_word:      in_arc_word,
                 position:      in_position,
                 window_start:  in_window_start,
                 window_length: in_window_length,
                 front_data_a:  in_front_data_a,
                 front_data_b:  in_front_data_b,
                 back_data_a:   in_back_data_a,
                 back_data_b:   in_back_data_b};
    end
  end

  // ---------------- queue state
  logic [PW-1:0] front_r, front_nxt;
  logic [PW-1:0] back_r, back_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic          rev_r, rev_nxt;
  logic [63:0]   fpa_r, fpa_nxt, fpb_r, fpb_nxt;
  logic [63:0]   bpa_r, bpa_nxt, bpb_r, bpb_nxt;

  // result registers
  logic          ok_r, ok_nxt;
  logic          ext_r, ext_nxt;
  logic          hit_r, hit_nxt;
  logic [63:0]   ea_r, ea_nxt, eb_r, eb_nxt;
  logic [10:0]   cnt_r, cnt_nxt;
  logic          out_valid_r;

  // entry memory port
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;
  logic signed [SW-1:0] log_addr;
  logic [31:0]          idx_mem [DEPTH];
  logic [63:0]          arc_mem [DEPTH];
  logic [31:0]          rd_idx_r;
  logic [63:0]          rd_arc_r;

  // pointer arithmetic on the widened view
  logic signed [SW-1:0] f_s, b_s, c_s, pos_s, start_s, len_s;
  logic signed [SW-1:0] peek_p, sel_f, sel_l, flip_f, flip_b, cnt_w;
  logic                 nonempty;

  assign f_s     = sx(front_r);
  assign b_s     = sx(back_r);
  assign c_s     = sx(cur_r);
  assign pos_s   = {{(SW-11){cmd_r.position[10]}}, cmd_r.position};
  assign start_s = {{(SW-10){1'b0}}, cmd_r.window_start};
  assign len_s   = {{(SW-11){1'b0}}, cmd_r.window_length};

  assign nonempty = (f_s <= b_s);
  // negative position counts from the back
  assign peek_p   = cmd_r.position[10] ? (pos_s + b_s + ONE_S) : (pos_s + f_s);
  assign sel_f    = f_s + start_s;
  assign sel_l    = sel_f + len_s - ONE_S;
  assign flip_f   = DM1_S - b_s;
  assign flip_b   = DM1_S - f_s;

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    cur_nxt   = cur_r;
    rev_nxt   = rev_r;
    fpa_nxt   = fpa_r;
    fpb_nxt   = fpb_r;
    bpa_nxt   = bpa_r;
    bpb_nxt   = bpb_r;
    ok_nxt    = 1'b0;
    ext_nxt   = 1'b0;
    hit_nxt   = 1'b0;
    ea_nxt    = '0;
    eb_nxt    = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    log_addr  = f_s;
    unique case (func_t'(cmd_r.func))
      FN_CLEAR: begin
        front_nxt = HALF_S[PW-1:0];
        cur_nxt   = HALF_S[PW-1:0];
        back_nxt  = HALFM1_S[PW-1:0];
        ok_nxt    = 1'b1;
      end
      FN_APPEND: begin
        if (b_s < DM1_S) begin
          log_addr = b_s + ONE_S;
          back_nxt = log_addr[PW-1:0];
          mem_we   = 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      FN_PREPEND: begin
        if (f_s > ZERO_S) begin
          log_addr  = f_s - ONE_S;
          front_nxt = log_addr[PW-1:0];
          mem_we    = 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      FN_PEEK_FRNT: begin
        if (nonempty) begin
          mem_re  = 1'b1;
          hit_nxt = 1'b1;
          ok_nxt  = 1'b1;
        end
      end
      FN_PEEK_POS: begin
        log_addr = peek_p;
        if (nonempty && peek_p >= f_s && peek_p <= b_s) begin
          mem_re  = 1'b1;
          hit_nxt = 1'b1;
          ok_nxt  = 1'b1;
        end
      end
      FN_REWIND: begin
        cur_nxt = front_r;
        ok_nxt  = nonempty;
      end
      FN_NEXT: begin
        log_addr = c_s;
        if (c_s <= b_s) begin
          mem_re  = 1'b1;
          hit_nxt = 1'b1;
          ok_nxt  = 1'b1;
          cur_nxt = cur_r + PW'(1);
          ext_nxt = (c_s == f_s) || (c_s == b_s);
          if (c_s == f_s) begin
            ea_nxt = fpa_r;
            eb_nxt = fpb_r;
          end else if (c_s == b_s) begin
            ea_nxt = bpa_r;
            eb_nxt = bpb_r;
          end
        end
      end
      FN_SIZE: begin
        ok_nxt = 1'b1;
      end
      FN_SELECT: begin
        if (sel_f <= D_S && sel_l < D_S) begin
          front_nxt = sel_f[PW-1:0];
          back_nxt  = sel_l[PW-1:0];
          ok_nxt    = 1'b1;
        end
      end
      FN_FLIP: begin
        front_nxt = flip_f[PW-1:0];
        back_nxt  = flip_b[PW-1:0];
        rev_nxt   = !rev_r;
        fpa_nxt   = bpa_r;
        fpb_nxt   = bpb_r;
        bpa_nxt   = fpa_r;
        bpb_nxt   = fpb_r;
        ok_nxt    = 1'b1;
      end
      FN_SET_END: begin
        fpa_nxt = cmd_r.front_data_a;
        fpb_nxt = cmd_r.front_data_b;
        bpa_nxt = cmd_r.back_data_a;
        bpb_nxt = cmd_r.back_data_b;
        ok_nxt  = 1'b1;
      end
      FN_GET_END: begin
        if (pos_s == f_s) begin
          ea_nxt = fpa_r;
          eb_nxt = fpb_r;
          ok_nxt = 1'b1;
        end else if (pos_s == b_s) begin
          ea_nxt = bpa_r;
          eb_nxt = bpb_r;
          ok_nxt = 1'b1;
        end
      end
      default: begin
        // unused codes: no change, ok low
      end
    endcase
    mem_addr = phys_addr(log_addr, rev_r);
    cnt_w    = sx(back_nxt) - sx(front_nxt) + ONE_S;
    cnt_nxt  = cnt_w[10:0];
  end

  // queue state and result registers update in the execute cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= HALF_S[PW-1:0];
      back_r      <= HALFM1_S[PW-1:0];
      cur_r       <= HALF_S[PW-1:0];
      rev_r       <= 1'b0;
      fpa_r       <= '0;
      fpb_r       <= '0;
      bpa_r       <= '0;
      bpb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_en;
      if (exec_en) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        cur_r   <= cur_nxt;
        rev_r   <= rev_nxt;
        fpa_r   <= fpa_nxt;
        fpb_r   <= fpb_nxt;
        bpa_r   <= bpa_nxt;
        bpb_r   <= bpb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      ok_r  <= ok_nxt;
      ext_r <= ext_nxt;
      hit_r <= hit_nxt;
      ea_r  <= ea_nxt;
      eb_r  <= eb_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // single-port entry memory, registered read
  always_ff @(posedge clk) begin
    if (exec_en && mem_we) begin
      idx_mem[mem_addr] <= cmd_r.seg_index;
      arc_mem[mem_addr] <= cmd_r.arc_word;
    end
    if (exec_en && mem_re) begin
      rd_idx_r <= idx_mem[mem_addr];
      rd_arc_r <= arc_mem[mem_addr];
    end
  end

  // ---------------- result ports
  assign out_valid        = out_valid_r;
  assign out_ok           = ok_r;
  assign out_read_index   = hit_r ? rd_idx_r : '0;
  assign out_read_arc     = hit_r ? rd_arc_r : '0;
  assign out_entry_count  = cnt_r;
  assign out_at_extremity = ext_r;
  assign out_end_data_a   = ea_r;
  assign out_end_data_b   = eb_r;

  // ---------------- assertions
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("transfer not followed by execute cycle");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en |=> out_valid)
    else $error("execute cycle without result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (f_s <= b_s + ONE_S) && (f_s >= ZERO_S) && (b_s < D_S))
    else $error("queue pointers out of order or out of range");

  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("entry memory read and write in one cycle");

endmodule

FILE: tb/tb_centered_array_deque.sv
`timescale 1ns / 1ps

// Self-checking bench for centered_array_deque.
// Every command is predicted at its transfer edge against a shadow copy of the
// deque state; the reply is queued and checked field by field when out_valid
// shows it.
module tb_centered_array_deque;
  import cad_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int TAIL_CYCLES  = 8;
  localparam int SHOW_LIMIT   = 40;

  // codes 12..15 have no operation behind them
  localparam logic [3:0] FN_FIRST_UNUSED = 4'd12;
  localparam logic [3:0] FN_LAST_CODE    = 4'd15;

  // one reply as the block presents it
  typedef struct packed {
    logic        ok;
    logic [31:0] read_index;
    logic [63:0] read_arc;
    logic [10:0] entry_count;
    logic        at_extremity;
    logic [63:0] end_data_a;
    logic [63:0] end_data_b;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         in_func = '0;
  logic signed [31:0] in_seg_index = '0;
  logic [63:0]        in_arc_word = '0;
  logic signed [10:0] in_position = '0;
  logic [9:0]         in_window_start = '0;
  logic [10:0]        in_window_length = '0;
  logic [63:0]        in_front_data_a = '0;
  logic [63:0]        in_front_data_b = '0;
  logic [63:0]        in_back_data_a = '0;
  logic [63:0]        in_back_data_b = '0;
  logic               out_valid;
  logic               out_ok;
  logic signed [31:0] out_read_index;
  logic [63:0]        out_read_arc;
  logic [10:0]        out_entry_count;
  logic               out_at_extremity;
  logic [63:0]        out_end_data_a;
  logic [63:0]        out_end_data_b;

  centered_array_deque #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_seg_index     (in_seg_index),
    .in_arc_word      (in_arc_word),
    .in_position      (in_position),
    .in_window_start  (in_window_start),
    .in_window_length (in_window_length),
    .in_front_data_a  (in_front_data_a),
    .in_front_data_b  (in_front_data_b),
    .in_back_data_a   (in_back_data_a),
    .in_back_data_b   (in_back_data_b),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_read_index   (out_read_index),
    .out_read_arc     (out_read_arc),
    .out_entry_count  (out_entry_count),
    .out_at_extremity (out_at_extremity),
    .out_end_data_a   (out_end_data_a),
    .out_end_data_b   (out_end_data_b)
  );

  // ---------------------------------------------------------------------------
  // Shadow deque state. Pointers are logical indexes; with the reversed flag
  // set, logical index L lives in physical slot DEPTH-1-L.
  // ---------------------------------------------------------------------------
  int          sh_front    = DEPTH / 2;
  int          sh_back     = DEPTH / 2 - 1;
  int          sh_cursor   = DEPTH / 2;
  bit          sh_reversed = 1'b0;
  logic [63:0] sh_front_pair [2] = '{64'd0, 64'd0};
  logic [63:0] sh_back_pair  [2] = '{64'd0, 64'd0};
  logic [31:0] sh_index_mem  [DEPTH];
  logic [63:0] sh_arc_mem    [DEPTH];
  // memory is undefined after reset: a slot is readable once written
  bit          sh_written    [DEPTH];

  reply_t      replies_due[$];
  int unsigned ops_sent       = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  bit          steady_stretch = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int slot_of(int logical);
    return sh_reversed ? DEPTH - 1 - logical : logical;
  endfunction

  // peek position: non-negative counts from the front, negative from the back
  function automatic int peek_target(int pos);
    return (pos < 0) ? pos + sh_back + 1 : pos + sh_front;
  endfunction

  function automatic void store_entry(int logical, cmd_t c);
    int s;
    s = slot_of(logical);
    sh_index_mem[s] = c.seg_index;
    sh_arc_mem[s]   = c.arc_word;
    sh_written[s]   = 1'b1;
  endfunction

  function automatic void fetch_entry(int logical, inout reply_t r);
    r.read_index = sh_index_mem[slot_of(logical)];
    r.read_arc   = sh_arc_mem[slot_of(logical)];
  endfunction

  // front pair wins when front and back point at the same index
  function automatic bit end_pair_at(int at, inout reply_t r);
    if (at == sh_front) begin
      r.end_data_a = sh_front_pair[0];
      r.end_data_b = sh_front_pair[1];
      return 1'b1;
    end
    if (at == sh_back) begin
      r.end_data_a = sh_back_pair[0];
      r.end_data_b = sh_back_pair[1];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one transferred command to the shadow state and returns its reply.
  function automatic reply_t predict_reply(cmd_t c);
    reply_t      r;
    int          pos, nf, nl, p, t;
    logic [63:0] wa, wb;
    r   = '0;
    pos = int'(c.position);
    case (c.func)
      FN_CLEAR: begin
        sh_front  = DEPTH / 2;
        sh_back   = DEPTH / 2 - 1;
        sh_cursor = DEPTH / 2;
        r.ok      = 1'b1;
      end
      FN_APPEND: if (sh_back < DEPTH - 1) begin
        sh_back++;
        store_entry(sh_back, c);
        r.ok = 1'b1;
      end
      FN_PREPEND: if (sh_front > 0) begin
        sh_front--;
        store_entry(sh_front, c);
        r.ok = 1'b1;
      end
      FN_PEEK_FRNT: if (sh_front <= sh_back) begin
        fetch_entry(sh_front, r);
        r.ok = 1'b1;
      end
      FN_PEEK_POS: if (sh_front <= sh_back) begin
        p = peek_target(pos);
        if (p >= sh_front && p <= sh_back) begin
          fetch_entry(p, r);
          r.ok = 1'b1;
        end
      end
      FN_REWIND: begin
        // cursor moves even when the queue is empty
        sh_cursor = sh_front;
        r.ok      = (sh_back >= sh_front);
      end
      FN_NEXT: if (sh_cursor <= sh_back) begin
        p = sh_cursor;
        fetch_entry(p, r);
        sh_cursor++;
        r.ok           = 1'b1;
        r.at_extremity = (p == sh_front || p == sh_back);
        void'(end_pair_at(p, r));
      end
      FN_SIZE: r.ok = 1'b1;
      FN_SELECT: begin
        nf = sh_front + int'(c.window_start);
        nl = nf + int'(c.window_length) - 1;
        if (nf <= DEPTH && nl < DEPTH) begin
          sh_front = nf;
          sh_back  = nl;
          r.ok     = 1'b1;
        end
      end
      FN_FLIP: begin
        t           = sh_back;
        sh_back     = DEPTH - 1 - sh_front;
        sh_front    = DEPTH - 1 - t;
        sh_reversed = !sh_reversed;
        wa = sh_front_pair[0];
        wb = sh_front_pair[1];
        sh_front_pair[0] = sh_back_pair[0];
        sh_front_pair[1] = sh_back_pair[1];
        sh_back_pair[0]  = wa;
        sh_back_pair[1]  = wb;
        r.ok = 1'b1;
      end
      FN_SET_END: begin
        sh_front_pair[0] = c.front_data_a;
        sh_front_pair[1] = c.front_data_b;
        sh_back_pair[0]  = c.back_data_a;
        sh_back_pair[1]  = c.back_data_b;
        r.ok = 1'b1;
      end
      FN_GET_END: r.ok = end_pair_at(pos, r);
      default: ;
    endcase
    r.entry_count = 11'(sh_back - sh_front + 1);
    return r;
  endfunction

  // True when the command would read a memory slot never written.
  function automatic bit touches_unwritten(cmd_t c);
    int p;
    case (c.func)
      FN_PEEK_FRNT: p = sh_front;
      FN_PEEK_POS:  p = peek_target(int'(c.position));
      FN_NEXT:      p = sh_cursor;
      default:      return 1'b0;
    endcase
    if (p > sh_back || p < 0) return 1'b0;
    // the walk cursor may sit in front of the window and still read
    if (c.func != FN_NEXT && p < sh_front) return 1'b0;
    return !sh_written[slot_of(p)];
  endfunction

  // command with every field random; callers override what matters
  function automatic cmd_t fresh_cmd(logic [3:0] f);
    cmd_t c;
    c.func          = f;
    c.seg_index     = $urandom;
    c.arc_word      = {$urandom, $urandom};
    c.position      = 11'($urandom);
    c.window_start  = 10'($urandom);
    c.window_length = 11'($urandom_range(0, DEPTH));
    c.front_data_a  = {$urandom, $urandom};
    c.front_data_b  = {$urandom, $urandom};
    c.back_data_a   = {$urandom, $urandom};
    c.back_data_b   = {$urandom, $urandom};
    return c;
  endfunction

  // Weighted operation mix; positions and windows mostly land in the queue.
  function automatic cmd_t random_op();
    cmd_t        c;
    int unsigned r;
    int          cnt, st;
    r   = $urandom_range(0, 99);
    cnt = sh_back - sh_front + 1;
    if (r < 18)      c = fresh_cmd(FN_APPEND);
    else if (r < 32) c = fresh_cmd(FN_PREPEND);
    else if (r < 40) c = fresh_cmd(FN_PEEK_FRNT);
    else if (r < 50) begin
      c = fresh_cmd(FN_PEEK_POS);
      if (cnt > 0 && $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1)) c.position = 11'($urandom_range(0, cnt - 1));
        else c.position = 11'(-int'($urandom_range(1, cnt)));
      end
    end
    else if (r < 55) c = fresh_cmd(FN_REWIND);
    else if (r < 70) c = fresh_cmd(FN_NEXT);
    else if (r < 73) c = fresh_cmd(FN_SIZE);
    else if (r < 79) begin
      c = fresh_cmd(FN_SELECT);
      if ($urandom_range(0, 3) != 0) begin
        st = $urandom_range(0, cnt);
        c.window_start  = 10'(st);
        c.window_length = 11'($urandom_range(0, cnt - st));
      end
    end
    else if (r < 83) c = fresh_cmd(FN_FLIP);
    else if (r < 86) c = fresh_cmd(FN_SET_END);
    else if (r < 93) begin
      c = fresh_cmd(FN_GET_END);
      case ($urandom_range(0, 3))
        0: c.position = 11'(sh_front);
        1: c.position = 11'(sh_back);
        2: c.position = 11'(sh_front + 1);
        default: ;
      endcase
    end
    else if (r < 96) c = fresh_cmd(FN_CLEAR);
    else c = fresh_cmd(4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE)));
    return c;
  endfunction

  // mostly back-to-back, some short gaps, rare long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one command and holds it until it transfers (start high, busy low
  // at the edge). The reply is predicted right at the transfer edge. start is
  // left high on return so a following command can go back to back.
  task automatic send_op(cmd_t c);
    int unsigned gap;
    if (touches_unwritten(c)) c.func = FN_SIZE;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_func          <= c.func;
    in_seg_index     <= c.seg_index;
    in_arc_word      <= c.arc_word;
    in_position      <= c.position;
    in_window_start  <= c.window_start;
    in_window_length <= c.window_length;
    in_front_data_a  <= c.front_data_a;
    in_front_data_b  <= c.front_data_b;
    in_back_data_a   <= c.back_data_a;
    in_back_data_b   <= c.back_data_b;
    do @(posedge clk); while (busy);
    replies_due.push_back(predict_reply(c));
    ops_sent++;
  endtask

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checker: the receiver never stalls, so every out_valid cycle is one
  // reply transfer at the edge that ends it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: reply with no command outstanding, expected none, actual ok=%b",
                   $time, out_ok);
      end else begin
        want = replies_due.pop_front();
        compare_field("ok",           64'(want.ok),           64'(out_ok));
        compare_field("read_index",   64'(want.read_index),   64'($unsigned(out_read_index)));
        compare_field("read_arc",     want.read_arc,          out_read_arc);
        compare_field("entry_count",  64'(want.entry_count),  64'(out_entry_count));
        compare_field("at_extremity", 64'(want.at_extremity), 64'(out_at_extremity));
        compare_field("end_data_a",   want.end_data_a,        out_end_data_a);
        compare_field("end_data_b",   want.end_data_b,        out_end_data_b);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies outstanding", $time, replies_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Fresh queue: nothing to read, walk already past the back, front pair matches
  // its own index even though the queue is empty.
  task automatic test_empty_queue();
    cmd_t c;
    send_op(fresh_cmd(FN_SIZE));
    send_op(fresh_cmd(FN_PEEK_FRNT));
    send_op(fresh_cmd(FN_REWIND));
    send_op(fresh_cmd(FN_NEXT));
    c = fresh_cmd(FN_GET_END);
    c.position = 11'(DEPTH / 2);
    send_op(c);
  endtask

  // Three entries with extreme contents, end data at the extremes, peeks in
  // and far out of range at both signs.
  task automatic test_grow_and_peek();
    cmd_t c;
    c = fresh_cmd(FN_APPEND);
    c.seg_index = 32'sh8000_0000;
    c.arc_word  = '1;
    send_op(c);
    c = fresh_cmd(FN_APPEND);
    c.seg_index = 32'sh7FFF_FFFF;
    c.arc_word  = '0;
    send_op(c);
    c = fresh_cmd(FN_PREPEND);
    c.seg_index = -32'sd1;
    c.arc_word  = 64'h5555_5555_5555_5555;
    send_op(c);
    c = fresh_cmd(FN_SET_END);
    c.front_data_a = '1;
    c.front_data_b = '0;
    c.back_data_a  = '0;
    c.back_data_b  = '1;
    send_op(c);
    send_op(fresh_cmd(FN_PEEK_FRNT));
    c = fresh_cmd(FN_PEEK_POS);
    c.position = 11'h3FF;
    send_op(c);
    c = fresh_cmd(FN_PEEK_POS);
    c.position = 11'h400;
    send_op(c);
  endtask

  // Full walk: extremity and end pairs at front and back, then one past.
  task automatic test_walk();
    send_op(fresh_cmd(FN_REWIND));
    repeat (4) send_op(fresh_cmd(FN_NEXT));
  endtask

  // Flip remaps reads; select: a window off the array, a one-entry window,
  // and an empty one.
  task automatic test_flip_and_select();
    cmd_t c;
    send_op(fresh_cmd(FN_FLIP));
    send_op(fresh_cmd(FN_PEEK_FRNT));
    c = fresh_cmd(FN_SELECT);
    c.window_start  = '1;
    c.window_length = 11'(DEPTH);
    send_op(c);
    c = fresh_cmd(FN_SELECT);
    c.window_start  = 10'd1;
    c.window_length = 11'd1;
    send_op(c);
    c = fresh_cmd(FN_SELECT);
    c.window_start  = '0;
    c.window_length = '0;
    send_op(c);
  endtask

  // Window pushed to the top slot so append hits the edge; flip brings it to
  // slot zero so prepend does too. Then an unused code.
  task automatic test_array_edges();
    cmd_t c;
    send_op(fresh_cmd(FN_CLEAR));
    c = fresh_cmd(FN_SELECT);
    c.window_start  = 10'(DEPTH / 2 - 1);
    c.window_length = 11'd1;
    send_op(c);
    send_op(fresh_cmd(FN_APPEND));
    send_op(fresh_cmd(FN_FLIP));
    send_op(fresh_cmd(FN_PREPEND));
    send_op(fresh_cmd(FN_LAST_CODE));
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------

  // Grow one way from mid-array until the edge refuses, then read around.
  task automatic test_fill_to_edge();
    func_t grow;
    grow = $urandom_range(0, 1) ? FN_APPEND : FN_PREPEND;
    send_op(fresh_cmd(FN_CLEAR));
    repeat (DEPTH / 2 + 1) send_op(fresh_cmd(grow));
    send_op(fresh_cmd(FN_REWIND));
    repeat (16) send_op(fresh_cmd(FN_NEXT));
    repeat (24) send_op(random_op());
  endtask

  // Bursts of either a grow-then-walk sequence or a free operation mix; some
  // bursts run with no gaps at all.
  task automatic test_random_traffic(int unsigned goal);
    int walk;
    while (ops_sent < goal) begin
      steady_stretch = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) send_op(fresh_cmd(FN_CLEAR));
        repeat ($urandom_range(1, 24))
          send_op(fresh_cmd($urandom_range(0, 1) ? FN_APPEND : FN_PREPEND));
        send_op(fresh_cmd(FN_REWIND));
        walk = sh_back - sh_front + 2;
        if (walk > 40) walk = 40;
        repeat (walk) send_op(fresh_cmd(FN_NEXT));
      end else begin
        repeat ($urandom_range(8, 40)) send_op(random_op());
      end
    end
    steady_stretch = 1'b0;
  endtask

  initial begin
    int unsigned goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_grow_and_peek();
    test_walk();
    test_flip_and_select();
    test_array_edges();

    goal = ops_sent + RANDOM_ITEMS;
    test_fill_to_edge();
    test_random_traffic(goal);

    // last transfer just happened; release start and drain
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/cad_pkg.sv
design/centered_array_deque.sv
tb/tb_centered_array_deque.sv
